// ===== rtl/kmio_pkg.sv =====
// kmio_pkg: shared types, function codes and the key table for the
// keyboard matrix I/O port block. No dependencies.
package kmio_pkg;

  localparam int NUM_ROWS        = 8;
  localparam int ROW_IDX_W       = $clog2(NUM_ROWS);
  localparam int NUM_MATRIX_KEYS = 41;
  localparam int JOY_W           = 5;
  localparam int JOY_IDX_W       = $clog2(JOY_W);

  // Function codes carried in tuser.
  localparam logic [1:0] FUNC_KEY   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [5:0] JOY_FIRST_CODE = 6'd41;
  localparam logic [5:0] JOY_LAST_CODE  = 6'd45;
  localparam logic [5:0] MATRIX_KEYS    = 6'd41;

  localparam logic [7:0] ROW_IDLE     = 8'hFF;
  localparam logic [7:0] BUS_IDLE     = 8'hFF;
  localparam logic [4:0] JOY_SEL_ADDR = 5'h1F;

  // Row and active-low mask for each matrix key; key zero clears a whole row.
  localparam logic [ROW_IDX_W-1:0] KEY_ROW [NUM_MATRIX_KEYS] = '{
    3'd0, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7};

  localparam logic [7:0] KEY_MASK [NUM_MATRIX_KEYS] = '{
    8'h00, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE,
    8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE,
    8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE,
    8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE};

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  key_code;
    logic        pressed;
    logic [15:0] port;
    logic [7:0]  out_data;
  } kmio_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] border_color;
    logic       speaker;
  } kmio_result_t;

endpackage

// ===== rtl/kmio_port_core.sv =====
// kmio_port_core: key matrix, joystick, border and speaker state with the
// single-pass update and port read logic. Depends on kmio_pkg.
module kmio_port_core
  import kmio_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  kmio_item_t   item,
  output kmio_result_t result
);

  logic [7:0]           key_rows_r   [NUM_ROWS];
  logic [7:0]           key_rows_nxt [NUM_ROWS];
  logic [JOY_W-1:0]     joy_r, joy_nxt;
  logic [2:0]           border_r, border_nxt;
  logic                 speaker_r, speaker_nxt;
  logic [7:0]           rd_data;
  logic [ROW_IDX_W-1:0] row_sel;
  logic [7:0]           row_mask;
  logic [JOY_IDX_W-1:0] joy_idx;

  always_comb begin
    key_rows_nxt = key_rows_r;
    joy_nxt      = joy_r;
    border_nxt   = border_r;
    speaker_nxt  = speaker_r;
    rd_data      = BUS_IDLE;
    row_sel      = '0;
    row_mask     = ROW_IDLE;
    joy_idx      = JOY_IDX_W'(item.key_code - JOY_FIRST_CODE);
    case (item.func)
      FUNC_KEY: begin
        if (item.key_code >= JOY_FIRST_CODE && item.key_code <= JOY_LAST_CODE) begin
          joy_nxt[joy_idx] = item.pressed;
        end else if (item.key_code < MATRIX_KEYS) begin
          row_sel  = KEY_ROW[item.key_code];
          row_mask = KEY_MASK[item.key_code];
          if (item.pressed) begin
            key_rows_nxt[row_sel] = key_rows_r[row_sel] & row_mask;
          end else begin
            key_rows_nxt[row_sel] = key_rows_r[row_sel] | ~row_mask;
          end
        end
      end
      FUNC_READ: begin
        if (!item.port[0]) begin
          // half-row select: every row whose high address bit is low
          for (int r = 0; r < NUM_ROWS; r++) begin
            if (!item.port[8+r]) rd_data = rd_data & key_rows_r[r];
          end
        end else if (item.port[4:0] == JOY_SEL_ADDR) begin
          rd_data = {{(8-JOY_W){1'b0}}, joy_r};
        end
      end
      FUNC_WRITE: begin
        if (!item.port[0]) begin
          border_nxt  = item.out_data[2:0];
          speaker_nxt = item.out_data[4];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) key_rows_r[r] <= ROW_IDLE;
      joy_r     <= '0;
      border_r  <= '0;
      speaker_r <= 1'b1;
    end else if (step_en) begin
      key_rows_r <= key_rows_nxt;
      joy_r      <= joy_nxt;
      border_r   <= border_nxt;
      speaker_r  <= speaker_nxt;
    end
  end

  assign result.read_data    = rd_data;
  assign result.border_color = border_nxt;
  assign result.speaker      = speaker_nxt;

  // border and speaker move only on a low-bit-0 port write
  a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && item.func == FUNC_WRITE && !item.port[0])
      |=> $stable(border_r) && $stable(speaker_r))
    else $error("border/speaker changed without a port write");

  // joystick state changes only on a key event
  a_joy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_en && item.func == FUNC_KEY) |=> $stable(joy_r))
    else $error("joystick bits changed without a key event");

  // a port read leaves joystick and latches alone
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.func == FUNC_READ
      |=> $stable(joy_r) && $stable(border_r) && $stable(speaker_r))
    else $error("port read changed state");

endmodule

// ===== rtl/keyboard_matrix_io_port.sv =====
// keyboard_matrix_io_port: top level, input beat register, result register
// and stream handshake. Depends on kmio_pkg and kmio_port_core.
//
// Emulated I/O port block of a home computer: an 8x8 active-low key
// matrix, a 5-bit joystick register, the border color latch and the
// speaker bit. Each input beat carries a function in in_tuser (key event,
// port read or port write); every beat yields exactly one result beat with
// the read byte (0xFF unless a read) and the border/speaker latches as they
// stand after that beat. Rate: one beat per clock sustained while out_tready
// is high. Each beat goes through the input register, a single pass of
// update/read logic and the result register, in that order. A stall
// on the output side holds one item in each register before in_tready
// drops. Key codes 0..40 hit the matrix by table, 41..45 are joystick
// right, left, down, up, fire; other codes do nothing.
module keyboard_matrix_io_port
  import kmio_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key_code[5:0], pressed[6], port[22:7], out_data[30:23]
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0], border_color[10:8], speaker[11]
);

  logic         s1_valid_r;
  kmio_item_t   s1_item_r;
  logic         out_valid_r;
  kmio_result_t out_res_r;
  kmio_result_t core_res;
  logic         s1_adv;
  logic         in_beat;
  kmio_item_t   in_item;

  // unpack the input beat
  assign in_item.func     = in_tuser;
  assign in_item.key_code = in_tdata[5:0];
  assign in_item.pressed  = in_tdata[6];
  assign in_item.port     = in_tdata[22:7];
  assign in_item.out_data = in_tdata[30:23];

  // stage 1 moves into the result register when that is empty or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_beat   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_beat || (s1_valid_r && !s1_adv);
      out_valid_r <= s1_adv || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) s1_item_r <= in_item;
    if (s1_adv)  out_res_r <= core_res;
  end

  // state is committed at the same edge the result is captured
  kmio_port_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (s1_item_r),
    .result  (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.speaker, out_res_r.border_color,
                       out_res_r.read_data};

  // every item leaving stage 1 lands in the result register
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item lost before result register");

  // only reads return anything other than the idle byte
  a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.func != FUNC_READ |=> out_res_r.read_data == BUS_IDLE)
    else $error("non-read beat returned data");

  // an empty input register always takes a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty stage");

  // a full pipe under stall must back-pressure
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while both stages stalled");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: stream-level testbench for keyboard_matrix_io_port, with its own key matrix,
// joystick and latch predictor, random burst/stall pacing and in-order result checking.
// Depends on kmio_pkg (types, function codes) and the RTL top level.
module tb;
  import kmio_pkg::*;

  // func code 3 is undefined: no state change, read byte idles high
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 8;     // extra wait after the result queue drains
  localparam int RANDOM_BEATS = 1100;
  localparam int MAX_PRINTS   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // key_code[5:0], pressed[6], port[22:7], out_data[30:23]
  logic [1:0]  in_tuser = FUNC_KEY;   // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // read_data[7:0], border_color[10:8], speaker[11]

  always #4 clk = ~clk;

  keyboard_matrix_io_port u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Stimulus feed and expected results, oldest first.
  kmio_item_t   beat_feed_q[$];
  kmio_result_t port_results_q[$];

  // Predictor state: active-low rows, active-high joystick, latches.
  logic [7:0] matrix_rows [NUM_ROWS];
  logic [4:0] joy_bits;
  logic [2:0] border_q;
  logic       speaker_q;

  int error_count = 0;
  int checked_count = 0;
  int key_beats = 0, read_beats = 0, write_beats = 0, spare_beats = 0;
  int kbd_reads = 0, joy_reads = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;

  // Sender pacing
  int burst_left = 1;
  int gap_left = 0;

  // Receiver pacing
  int stall_mode = 0;
  int mode_left = 100;
  int pattern_cnt = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic matrix_clear();
    for (int r = 0; r < NUM_ROWS; r++)
      matrix_rows[r] = 8'hFF;
    joy_bits  = '0;
    border_q  = '0;
    speaker_q = 1'b1;
  endtask

  // Matrix keys 1..40 come in groups of five, one group per row. Row order of
  // the groups is 3,4,2,5,1,6,0,7; even groups walk bit 0 up to bit 4, odd
  // groups walk bit 4 down to bit 0.
  function automatic logic [2:0] key_row(input logic [5:0] code);
    logic [2:0] order [8];
    int grp;
    order = '{3'd3, 3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd0, 3'd7};
    grp = (int'(code) - 1) / 5;
    return order[grp];
  endfunction

  function automatic int key_bit(input logic [5:0] code);
    int grp;
    int pos;
    grp = (int'(code) - 1) / 5;
    pos = (int'(code) - 1) % 5;
    return (grp % 2 == 0) ? pos : 4 - pos;
  endfunction

  // Applies one beat to the predictor state and returns the result it yields.
  function automatic kmio_result_t predict_port_beat(input kmio_item_t it);
    kmio_result_t res;
    res.read_data = 8'hFF;
    case (it.func)
      FUNC_KEY: begin
        if (it.key_code >= JOY_FIRST_CODE && it.key_code <= JOY_LAST_CODE) begin
          joy_bits[it.key_code - JOY_FIRST_CODE] = it.pressed;
        end else if (it.key_code == 6'd0) begin
          // key zero presses or releases all of row 0
          matrix_rows[0] = it.pressed ? 8'h00 : 8'hFF;
        end else if (it.key_code < MATRIX_KEYS) begin
          matrix_rows[key_row(it.key_code)][key_bit(it.key_code)] = ~it.pressed;
        end
      end
      FUNC_READ: begin
        if (!it.port[0]) begin
          for (int r = 0; r < NUM_ROWS; r++)
            if (!it.port[8 + r]) res.read_data &= matrix_rows[r];
        end else if (it.port[4:0] == 5'h1F) begin
          res.read_data = {3'b000, joy_bits};
        end
      end
      FUNC_WRITE: begin
        if (!it.port[0]) begin
          border_q  = it.out_data[2:0];
          speaker_q = it.out_data[4];
        end
      end
      default: ;
    endcase
    res.border_color = border_q;
    res.speaker      = speaker_q;
    return res;
  endfunction

  task automatic queue_beat(input logic [1:0] func, input logic [5:0] code,
                            input logic pressed, input logic [15:0] port,
                            input logic [7:0] data);
    kmio_item_t it;
    it.func     = func;
    it.key_code = code;
    it.pressed  = pressed;
    it.port     = port;
    it.out_data = data;
    beat_feed_q.push_back(it);
  endtask

  // Random beat, weighted toward meaningful key events and reads that select key
  // rows or the joystick; fields a function ignores are still random.
  task automatic queue_random_beat();
    int sel;
    int r;
    logic [5:0]  code;
    logic [15:0] port;
    logic [1:0]  func;
    code = 6'($urandom_range(1, 40));
    port = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 36) func = FUNC_KEY;
    else if (sel < 74) func = FUNC_READ;
    else if (sel < 95) func = FUNC_WRITE;
    else func = FUNC_SPARE;
    case (func)
      FUNC_KEY: begin
        sel = $urandom_range(0, 99);
        if (sel < 3) code = 6'd0;
        else if (sel < 10) code = 6'($urandom_range(46, 63));
        else if (sel < 35) code = 6'($urandom_range(41, 45));
      end
      FUNC_READ: begin
        sel = $urandom_range(0, 3);
        r = $urandom_range(0, NUM_ROWS - 1);
        if (sel == 0) port[0] = 1'b0;
        else if (sel == 1) port = {~(8'h01 << r), port[7:1], 1'b0};
        else if (sel == 2) port[4:0] = 5'h1F;
      end
      FUNC_WRITE: begin
        if ($urandom_range(0, 3) != 0) port[0] = 1'b0;
      end
      default: code = 6'($urandom);
    endcase
    queue_beat(func, code, 1'($urandom_range(0, 1)), port, 8'($urandom));
  endtask

  // Driver: next beat at the falling edge once the current one was taken.
  always @(negedge clk) begin : drive_proc
    kmio_item_t nxt;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (beat_feed_q.size() > 0) begin
        nxt = beat_feed_q.pop_front();
        in_tdata  <= {1'b0, nxt.out_data, nxt.port, nxt.pressed, nxt.key_code};
        in_tuser  <= nxt.func;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always-ready, random, periodic and long-hold
  // stall patterns every so often.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      mode_left   <= $urandom_range(40, 300);
      pattern_cnt <= 0;
    end else begin
      mode_left   <= mode_left - 1;
      pattern_cnt <= pattern_cnt + 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      2: out_tready <= (pattern_cnt % 4 == 3);
      default: out_tready <= (pattern_cnt % 24 >= 16);
    endcase
  end

  // Monitor: predict on accepted input beats, check accepted result beats.
  always @(posedge clk) begin : monitor_proc
    kmio_item_t   it;
    kmio_result_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      it.func     = in_tuser;
      it.key_code = in_tdata[5:0];
      it.pressed  = in_tdata[6];
      it.port     = in_tdata[22:7];
      it.out_data = in_tdata[30:23];
      port_results_q.push_back(predict_port_beat(it));
      case (it.func)
        FUNC_KEY:   key_beats++;
        FUNC_READ: begin
          read_beats++;
          if (!it.port[0] && it.port[15:8] != 8'hFF) kbd_reads++;
          else if (it.port[0] && it.port[4:0] == 5'h1F) joy_reads++;
        end
        FUNC_WRITE: write_beats++;
        default:    spare_beats++;
      endcase
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (port_results_q.size() == 0) begin
        report_mismatch("unexpected result beat", int'(out_tdata), 0);
      end else begin
        want = port_results_q.pop_front();
        checked_count++;
        if (out_tdata[7:0] != want.read_data)
          report_mismatch("read_data", int'(out_tdata[7:0]), int'(want.read_data));
        if (out_tdata[10:8] != want.border_color)
          report_mismatch("border_color", int'(out_tdata[10:8]),
                          int'(want.border_color));
        if (out_tdata[11] != want.speaker)
          report_mismatch("speaker", int'(out_tdata[11]), int'(want.speaker));
      end
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, port_results_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    matrix_clear();

    // Directed: idle reads, key zero, row and joystick selects, dead codes,
    // latch writes at both address parities, undefined function code.
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'hFFFE, 8'h00);  // no row selected
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'h0000, 8'h00);  // all rows, none pressed
    queue_beat(FUNC_KEY,   6'd0,  1'b1, 16'h0000, 8'h00);  // row 0 fully pressed
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'hFEFE, 8'h00);
    queue_beat(FUNC_KEY,   6'd40, 1'b1, 16'hFFFF, 8'hFF);  // last matrix key, row 7
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'h7FFE, 8'h00);
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'h0000, 8'h00);  // AND of all rows
    queue_beat(FUNC_KEY,   6'd0,  1'b0, 16'h0000, 8'h00);  // release row 0
    queue_beat(FUNC_KEY,   6'd1,  1'b1, 16'h0000, 8'h00);  // first matrix key, row 3
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'hF7FE, 8'h00);
    queue_beat(FUNC_KEY,   6'd41, 1'b1, 16'h0000, 8'h00);  // joystick right
    queue_beat(FUNC_KEY,   6'd45, 1'b1, 16'h0000, 8'h00);  // joystick fire
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'h001F, 8'h00);
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'hFFFF, 8'h00);
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'h0001, 8'h00);  // neither select
    queue_beat(FUNC_KEY,   6'd63, 1'b1, 16'h0000, 8'h00);  // beyond table
    queue_beat(FUNC_KEY,   6'd46, 1'b1, 16'h0000, 8'h00);
    queue_beat(FUNC_READ,  6'd0,  1'b0, 16'h0000, 8'h00);
    queue_beat(FUNC_WRITE, 6'd0,  1'b0, 16'h00FE, 8'hFF);  // border 7, speaker 1
    queue_beat(FUNC_WRITE, 6'd0,  1'b0, 16'hFFFF, 8'h00);  // odd address, ignored
    queue_beat(FUNC_WRITE, 6'd0,  1'b0, 16'h0000, 8'h00);  // border 0, speaker 0
    queue_beat(FUNC_WRITE, 6'd0,  1'b0, 16'hFFFE, 8'h15);  // border 5, speaker 1
    queue_beat(FUNC_SPARE, 6'd63, 1'b1, 16'hFFFE, 8'hFF);
    queue_beat(FUNC_KEY,   6'd41, 1'b0, 16'h0000, 8'h00);
    queue_beat(FUNC_KEY,   6'd45, 1'b0, 16'h0000, 8'h00);

    for (int n = 0; n < RANDOM_BEATS; n++)
      queue_random_beat();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (beat_feed_q.size() != 0 || in_tvalid) @(posedge clk);
    while (port_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (port_results_q.size() != 0)
      report_mismatch("results left over", port_results_q.size(), 0);

    $display("Checked %0d result beats: %0d key events, %0d reads, %0d writes, %0d spare",
             checked_count, key_beats, read_beats, write_beats, spare_beats);
    $display("Reads hitting the key matrix: %0d, the joystick: %0d", kbd_reads, joy_reads);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kmio_pkg.sv
rtl/kmio_port_core.sv
rtl/keyboard_matrix_io_port.sv
test/tb.sv
